// ===== hw/rtl/qps_pkg.sv =====
// Shared constants, types and the quadrature transition table of the position servo.
`timescale 1ns / 1ps
`default_nettype none

package qps_pkg;

  localparam int CountW = 32;
  localparam int DutyW = 10;
  localparam int LimW = 10;
  localparam int DutyFull = 1000;

  localparam logic [2:0] OpTick = 3'd0;
  localparam logic [2:0] OpMove = 3'd1;
  localparam logic [2:0] OpRotate = 3'd2;
  localparam logic [2:0] OpStart = 3'd3;
  localparam logic [2:0] OpStop = 3'd4;

  localparam logic [1:0] ModeStopped = 2'd0;
  localparam logic [1:0] ModeLinear = 2'd1;
  localparam logic [1:0] ModeRotate = 2'd2;

  localparam logic signed [33:0] InvMoveQ16 = 34'sd59578;
  localparam logic signed [33:0] InvRotQ16 = 34'sd35425;

  typedef struct packed {
    logic             dir;
    logic [DutyW-1:0] duty;
    logic             zero;
  } drive_t;

  function automatic logic signed [1:0] step_lut(input logic [3:0] code);
    logic signed [1:0] s;
    case (code)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qps_decoder.sv =====
// Quadrature transition decoder that steps one wrapping position count.
`timescale 1ns / 1ps
`default_nettype none

module qps_decoder
  import qps_pkg::*;
(
  input  wire logic [1:0]        prev_i,
  input  wire logic [1:0]        cur_i,
  input  wire logic [CountW-1:0] pos_i,
  output logic      [CountW-1:0] pos_o
);

  logic signed [1:0] step;

  always_comb begin
    step = step_lut({prev_i, cur_i});
    pos_o = pos_i + CountW'(step);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qps_goal.sv =====
// New goal from a count plus a Q16 offset, truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none

module qps_goal
  import qps_pkg::*;
(
  input  wire logic        [CountW-1:0] pos_i,
  input  wire logic signed [33:0]       offset_i,
  output logic             [CountW-1:0] goal_o
);

  localparam int SumW = CountW + 17;

  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] biased;

  always_comb begin
    sum = $signed({pos_i[CountW-1], pos_i, 16'h0000}) + SumW'(offset_i);
    biased = sum + (sum[SumW-1] ? SumW'(65535) : SumW'(0));
    goal_o = biased[CountW+15:16];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qps_ctrl.sv =====
// Proportional controller with saturation, deadband and speed clamp for one motor.
`timescale 1ns / 1ps
`default_nettype none

module qps_ctrl
  import qps_pkg::*;
(
  input  wire logic              enable_i,
  input  wire logic [CountW-1:0] goal_i,
  input  wire logic [CountW-1:0] pos_i,
  input  wire logic [LimW-1:0]   lim_i,
  output drive_t                 drive_o
);

  logic signed [CountW-1:0] diff;
  logic signed [15:0]       d16;
  logic signed [16:0]       err;
  logic signed [16:0]       lim;
  logic signed [16:0]       cmd;

  always_comb begin
    diff = $signed(goal_i - pos_i);
    d16 = diff[15:0];
    lim = $signed({7'd0, lim_i});
    if (diff > 32'sd1092) begin
      err = 17'sd32767;
    end else if (diff < -32'sd1092) begin
      err = -17'sd32768;
    end else begin
      err = 17'((d16 <<< 5) - (d16 <<< 1));
    end
    if (err > -17'sd100 && err < 17'sd100) begin
      err = 17'sd0;
    end
    if (err > lim) begin
      cmd = lim;
    end else if (err < -lim) begin
      cmd = -lim;
    end else begin
      cmd = err;
    end
    if (!enable_i) begin
      cmd = 17'sd0;
    end
    drive_o.dir = cmd > 17'sd0;
    drive_o.zero = cmd == 17'sd0;
    if (cmd > 17'sd0) begin
      drive_o.duty = DutyW'(17'(DutyFull) - cmd);
    end else begin
      drive_o.duty = DutyW'(-cmd);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/quadrature_position_servo_unit.sv =====
// Top level of the two-wheel quadrature position servo.
// An accepted item waits in the input register; its result goes to the output register.
// Throughput: one item per cycle if out_stall_i is low; count, goal, mode update in one pass.
// The input register accepts a new item while a finished result waits to be taken, if empty.
// Reset halts the servo, stops motion and clears counts, goals, phases and the speed limit.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_position_servo_unit
  import qps_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [2:0]          operation_i,
  input  wire logic signed [15:0]  amount_i,
  input  wire logic                enc_one_a_i,
  input  wire logic                enc_one_b_i,
  input  wire logic                enc_two_a_i,
  input  wire logic                enc_two_b_i,
  input  wire logic                cfg_we_i,
  input  wire logic [LimW-1:0]     cfg_wdata_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     motor_one_dir_o,
  output logic [DutyW-1:0]         motor_one_duty_o,
  output logic                     motor_two_dir_o,
  output logic [DutyW-1:0]         motor_two_duty_o,
  output logic                     motor_idle_o,
  output logic [1:0]               motion_mode_o,
  output logic signed [CountW-1:0] count_one_o,
  output logic signed [CountW-1:0] count_two_o
);

  logic              in_vld_q;
  logic [2:0]        op_q;
  logic signed [15:0] amt_q;
  logic [1:0]        code_one_q;
  logic [1:0]        code_two_q;

  logic [LimW-1:0]   speed_limit_q;
  logic [1:0]        phase_one_q, phase_two_q;
  logic [CountW-1:0] pos_one_q, pos_one_d;
  logic [CountW-1:0] pos_two_q, pos_two_d;
  logic [CountW-1:0] goal_one_q, goal_one_d;
  logic [CountW-1:0] goal_two_q, goal_two_d;
  logic [1:0]        mode_q, mode_d;
  logic              halted_q, halted_d;

  logic              out_vld_q;
  drive_t            drv_one_q, drv_one_d;
  drive_t            drv_two_q, drv_two_d;
  logic              sleep_q, sleep_d;

  logic              advance, fire, accept;
  logic [CountW-1:0] tick_one, tick_two;
  logic [CountW-1:0] new_goal_one, new_goal_two;
  logic signed [33:0] off_one, off_two;
  logic [LimW-1:0]   lim;
  logic              ctrl_en;
  drive_t            ctrl_one, ctrl_two;

  assign advance = !out_vld_q || !out_stall_i;
  assign fire = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign accept = in_valid_i && !in_stall_o;

  assign lim = (speed_limit_q > LimW'(DutyFull)) ? LimW'(DutyFull) : speed_limit_q;
  assign ctrl_en = !halted_q && (mode_q != ModeStopped);

  always_comb begin
    if (op_q == OpRotate) begin
      off_one = 34'(amt_q) * InvRotQ16;
      off_two = -off_one;
    end else begin
      off_one = 34'(amt_q) * InvMoveQ16;
      off_two = off_one;
    end
  end

  qps_decoder u_dec_one (
    .prev_i(phase_one_q),
    .cur_i (code_one_q),
    .pos_i (pos_one_q),
    .pos_o (tick_one)
  );

  qps_decoder u_dec_two (
    .prev_i(phase_two_q),
    .cur_i (code_two_q),
    .pos_i (pos_two_q),
    .pos_o (tick_two)
  );

  qps_goal u_goal_one (
    .pos_i   (pos_one_q),
    .offset_i(off_one),
    .goal_o  (new_goal_one)
  );

  qps_goal u_goal_two (
    .pos_i   (pos_two_q),
    .offset_i(off_two),
    .goal_o  (new_goal_two)
  );

  qps_ctrl u_ctrl_one (
    .enable_i(ctrl_en),
    .goal_i  (goal_one_q),
    .pos_i   (tick_one),
    .lim_i   (lim),
    .drive_o (ctrl_one)
  );

  qps_ctrl u_ctrl_two (
    .enable_i(ctrl_en),
    .goal_i  (goal_two_q),
    .pos_i   (tick_two),
    .lim_i   (lim),
    .drive_o (ctrl_two)
  );

  always_comb begin
    pos_one_d = pos_one_q;
    pos_two_d = pos_two_q;
    goal_one_d = goal_one_q;
    goal_two_d = goal_two_q;
    mode_d = mode_q;
    halted_d = halted_q;
    drv_one_d = '{dir: 1'b0, duty: '0, zero: 1'b1};
    drv_two_d = '{dir: 1'b0, duty: '0, zero: 1'b1};
    sleep_d = 1'b0;
    case (op_q)
      OpTick: begin
        pos_one_d = tick_one;
        pos_two_d = tick_two;
        drv_one_d = ctrl_one;
        drv_two_d = ctrl_two;
        sleep_d = ctrl_one.zero && ctrl_two.zero;
        if (ctrl_en && ctrl_one.zero && ctrl_two.zero) begin
          mode_d = ModeStopped;
        end
      end
      OpMove: begin
        mode_d = ModeLinear;
        goal_one_d = new_goal_one;
        goal_two_d = new_goal_two;
      end
      OpRotate: begin
        mode_d = ModeRotate;
        goal_one_d = new_goal_one;
        goal_two_d = new_goal_two;
      end
      OpStart: begin
        halted_d = 1'b0;
      end
      OpStop: begin
        halted_d = 1'b1;
      end
      default: begin
        halted_d = halted_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= operation_i;
      amt_q <= amount_i;
      code_one_q <= {enc_one_a_i, enc_one_b_i};
      code_two_q <= {enc_two_b_i, enc_two_a_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q <= '0;
      phase_one_q <= 2'd0;
      phase_two_q <= 2'd0;
      pos_one_q <= '0;
      pos_two_q <= '0;
      goal_one_q <= '0;
      goal_two_q <= '0;
      mode_q <= ModeStopped;
      halted_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        speed_limit_q <= cfg_wdata_i;
      end
      if (fire) begin
        if (op_q == OpTick) begin
          phase_one_q <= code_one_q;
          phase_two_q <= code_two_q;
        end
        pos_one_q <= pos_one_d;
        pos_two_q <= pos_two_d;
        goal_one_q <= goal_one_d;
        goal_two_q <= goal_two_d;
        mode_q <= mode_d;
        halted_q <= halted_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      drv_one_q <= drv_one_d;
      drv_two_q <= drv_two_d;
      sleep_q <= sleep_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign motor_one_dir_o = drv_one_q.dir;
  assign motor_one_duty_o = drv_one_q.duty;
  assign motor_two_dir_o = drv_two_q.dir;
  assign motor_two_duty_o = drv_two_q.duty;
  assign motor_idle_o = sleep_q;
  assign motion_mode_o = mode_q;
  assign count_one_o = $signed(pos_one_q);
  assign count_two_o = $signed(pos_two_q);

endmodule

`default_nettype wire
